### rtl/jsu_pkg.sv
// Shared types, constants and helper functions for the JSON string unescaper.
package jsu_pkg;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_U = 8'h75;

   localparam logic [15:0] SURR_LO = 16'hD800;
   localparam logic [15:0] SURR_HI = 16'hDFFF;
   localparam logic [15:0] REPL_CHAR = 16'hFFFD;
   localparam logic [15:0] ONE_BYTE_LIM = 16'h0080;
   localparam logic [15:0] TWO_BYTE_LIM = 16'h0800;
   localparam logic [7:0] LEAD2 = 8'hC0;
   localparam logic [7:0] LEAD3 = 8'hE0;
   localparam logic [7:0] CONT = 8'h80;
   localparam logic [5:0] CONT_MASK = 6'h3F;

   typedef struct packed {
      logic [2:0][7:0] data;
      logic [1:0] nbytes;
      logic ended;
   } entry_type;

   typedef struct packed {
      logic valid;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_digit(input logic [7:0] b);
      hex_type h;
      h.valid = 1'b1;
      h.value = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         h.value = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         h.value = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         h.value = 4'(b - 8'h37);
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

   function automatic logic [7:0] esc_map(input logic [7:0] b);
      logic [7:0] r;
      case (b)
         8'h6E: begin r = 8'h0A; end
         8'h74: begin r = 8'h09; end
         8'h72: begin r = 8'h0D; end
         8'h62: begin r = 8'h08; end
         8'h66: begin r = 8'h0C; end
         default: begin r = b; end
      endcase
      return r;
   endfunction

endpackage

### rtl/jsu_front.sv
// Front end: escape and hex decoding, capacity tracking, word grouping.
module jsu_front #(
   parameter int COUNT_BITS = 20,
   parameter int CW = 23
) (
   input  logic clock,
   input  logic reset,
   input  logic [CW-1:0] lim,
   input  logic accept,
   input  logic [7:0] in_byte,
   input  logic in_last,
   output logic push,
   output jsu_pkg::entry_type entry,
   output logic [COUNT_BITS-1:0] base
);

   localparam logic [2:0] MODE_TEXT = 3'd0;
   localparam logic [2:0] MODE_ESC = 3'd1;
   localparam logic [2:0] MODE_HEX0 = 3'd2;
   localparam logic [2:0] MODE_HEX3 = 3'd5;

   logic [2:0] mode_ff, mode_in;
   logic [15:0] hex_ff, hex_in;
   logic open_ff, open_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic fin_ff, fin_in;

   jsu_pkg::hex_type dig;
   logic [15:0] cp;
   logic [CW-1:0] cnt_ext;
   logic [CW-1:0] cnt_after;
   logic ended;

   always_comb begin
      mode_in = mode_ff;
      hex_in = hex_ff;
      open_in = open_ff;
      cnt_in = cnt_ff;
      fin_in = fin_ff;
      ended = 1'b0;
      entry = '0;
      dig = jsu_pkg::hex_digit(in_byte);
      cp = 16'd0;
      cnt_ext = CW'(cnt_ff);
      if (fin_ff) begin
         ended = 1'b0;
      end else if (cnt_ext >= lim) begin
         ended = 1'b1;
      end else begin
         case (mode_ff)
            MODE_TEXT: begin
               if (in_byte == jsu_pkg::CH_QUOTE) begin
                  ended = 1'b1;
               end else if (in_byte == jsu_pkg::CH_BSLASH && !in_last) begin
                  mode_in = MODE_ESC;
               end else begin
                  entry.data[0] = in_byte;
                  entry.nbytes = 2'd1;
               end
            end
            MODE_ESC: begin
               mode_in = MODE_TEXT;
               if (in_byte == jsu_pkg::CH_U) begin
                  mode_in = MODE_HEX0;
                  hex_in = 16'd0;
                  open_in = 1'b1;
               end else begin
                  entry.data[0] = jsu_pkg::esc_map(in_byte);
                  entry.nbytes = 2'd1;
               end
            end
            default: begin
               if (open_ff && dig.valid) begin
                  hex_in = {hex_ff[11:0], dig.value};
               end else begin
                  open_in = 1'b0;
               end
               if (mode_ff >= MODE_HEX3) begin
                  mode_in = MODE_TEXT;
                  cp = hex_in;
                  if (cp >= jsu_pkg::SURR_LO && cp <= jsu_pkg::SURR_HI) begin
                     cp = jsu_pkg::REPL_CHAR;
                  end
                  if (cp < jsu_pkg::ONE_BYTE_LIM) begin
                     entry.data[0] = cp[7:0];
                     entry.nbytes = 2'd1;
                  end else if (cp < jsu_pkg::TWO_BYTE_LIM) begin
                     if (cnt_ext + CW'(2) > lim) begin
                        ended = 1'b1;
                     end else begin
                        entry.data[0] = jsu_pkg::LEAD2 | {3'd0, cp[10:6]};
                        entry.data[1] = jsu_pkg::CONT | {2'd0, cp[5:0] & jsu_pkg::CONT_MASK};
                        entry.nbytes = 2'd2;
                     end
                  end else begin
                     if (cnt_ext + CW'(3) > lim) begin
                        ended = 1'b1;
                     end else begin
                        entry.data[0] = jsu_pkg::LEAD3 | {4'd0, cp[15:12]};
                        entry.data[1] = jsu_pkg::CONT | {2'd0, cp[11:6]};
                        entry.data[2] = jsu_pkg::CONT | {2'd0, cp[5:0] & jsu_pkg::CONT_MASK};
                        entry.nbytes = 2'd3;
                     end
                  end
               end else begin
                  mode_in = mode_ff + 3'd1;
               end
            end
         endcase
      end
      cnt_after = cnt_ext + CW'(entry.nbytes);
      if (!fin_ff) begin
         if (cnt_after >= lim || in_last) begin
            ended = 1'b1;
         end
         fin_in = ended;
         cnt_in = cnt_after[COUNT_BITS-1:0];
      end
      entry.ended = ended;
      if (in_last) begin
         mode_in = MODE_TEXT;
         hex_in = 16'd0;
         open_in = 1'b1;
         cnt_in = '0;
         fin_in = 1'b0;
      end
   end

   assign base = cnt_ff;
   assign push = accept && (entry.nbytes != 2'd0 || entry.ended);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_TEXT;
         hex_ff <= 16'd0;
         open_ff <= 1'b1;
         cnt_ff <= '0;
         fin_ff <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         hex_ff <= hex_in;
         open_ff <= open_in;
         cnt_ff <= cnt_in;
         fin_ff <= fin_in;
      end
   end

endmodule

### rtl/jsu_queue.sv
// Small word queue between the decoder front end and the output back end.
module jsu_queue #(
   parameter int COUNT_BITS = 20
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  jsu_pkg::entry_type push_entry,
   input  logic [COUNT_BITS-1:0] push_base,
   input  logic pop,
   output logic full,
   output logic empty,
   output jsu_pkg::entry_type head_entry,
   output logic [COUNT_BITS-1:0] head_base
);

   jsu_pkg::entry_type ent_ff [jsu_pkg::QDEPTH];
   logic [COUNT_BITS-1:0] base_ff [jsu_pkg::QDEPTH];
   logic [jsu_pkg::QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [jsu_pkg::QCNT_W-1:0] cnt_ff, cnt_in;

   assign full = (cnt_ff == jsu_pkg::QCNT_W'(jsu_pkg::QDEPTH));
   assign empty = (cnt_ff == '0);
   assign head_entry = ent_ff[rd_ff];
   assign head_base = base_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ff] <= push_entry;
         base_ff[wr_ff] <= push_base;
      end
   end

endmodule

### rtl/jsu_back.sv
// Back end: splits queued groups into single output words.
module jsu_back #(
   parameter int COUNT_BITS = 20
) (
   input  logic clock,
   input  logic reset,
   input  logic empty,
   input  jsu_pkg::entry_type head_entry,
   input  logic [COUNT_BITS-1:0] head_base,
   output logic pop,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic rsp_byte_valid,
   output logic rsp_end_of_string,
   output logic [19:0] rsp_out_length
);

   localparam int SW = (COUNT_BITS + 2 > 20) ? COUNT_BITS + 2 : 20;

   logic [1:0] idx_ff, idx_in;
   logic valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic bvalid_ff;
   logic eos_ff;
   logic [19:0] len_ff;

   logic load;
   logic last_beat;
   logic [1:0] beats_last;
   logic [7:0] cur_byte;
   logic [SW-1:0] len_sum;

   always_comb begin
      beats_last = (head_entry.nbytes == 2'd0) ? 2'd0 : head_entry.nbytes - 2'd1;
      last_beat = (idx_ff == beats_last);
      load = !empty && (!valid_ff || !rsp_stall);
      pop = load && last_beat;
      idx_in = idx_ff;
      if (load) begin
         idx_in = last_beat ? 2'd0 : idx_ff + 2'd1;
      end
      valid_in = load ? 1'b1 : (valid_ff && rsp_stall);
      case (idx_ff)
         2'd0: begin cur_byte = head_entry.data[0]; end
         2'd1: begin cur_byte = head_entry.data[1]; end
         2'd2: begin cur_byte = head_entry.data[2]; end
         default: begin cur_byte = 8'd0; end
      endcase
      if (head_entry.nbytes == 2'd0) begin
         len_sum = SW'(head_base);
      end else begin
         len_sum = SW'(head_base) + SW'(idx_ff) + SW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= (head_entry.nbytes == 2'd0) ? 8'd0 : cur_byte;
         bvalid_ff <= (head_entry.nbytes != 2'd0);
         eos_ff <= head_entry.ended && last_beat;
         len_ff <= len_sum[19:0];
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_byte_valid = bvalid_ff;
   assign rsp_end_of_string = eos_ff;
   assign rsp_out_length = len_ff;

endmodule

### rtl/json_string_unescape.sv
// JSON string unescaper top level: capacity register, decoder front, queue, output back.
// Takes one raw byte of a JSON string body per cycle and returns the unescaped
// bytes, one word per cycle while rsp_stall is low; a \uXXXX escape yields up to
// three UTF-8 bytes, which leave the output register as separate words. A four-entry
// queue between decoder and output lets input keep flowing while a multi-byte
// group drains; input stalls only when that queue is full. The capacity
// register is written through csr_wr_en and csr_wr_data and must only change
// while no string word is in flight.
module json_string_unescape #(
   parameter int COUNT_BITS = 20
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_wr_en,
   input  logic [20:0] csr_wr_data,
   input  logic req_valid,
   output logic req_stall,
   input  logic [7:0] req_in_byte,
   input  logic req_in_last,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic rsp_byte_valid,
   output logic rsp_end_of_string,
   output logic [19:0] rsp_out_length
);

   localparam int CW = ((COUNT_BITS > 21) ? COUNT_BITS : 21) + 2;
   localparam logic [CW-1:0] COUNT_MAX = (CW'(1) << COUNT_BITS) - CW'(1);
   localparam logic [CW-1:0] RESET_LIM = (CW'(1048575) > COUNT_MAX) ? COUNT_MAX : CW'(1048575);

   logic [CW-1:0] lim_ff, lim_in;
   logic accept;
   logic push, pop, q_full, q_empty;
   jsu_pkg::entry_type push_entry, head_entry;
   logic [COUNT_BITS-1:0] push_base, head_base;

   always_comb begin
      lim_in = lim_ff;
      if (csr_wr_en) begin
         lim_in = (csr_wr_data == 21'd0) ? '0 : CW'(csr_wr_data) - CW'(1);
         if (lim_in > COUNT_MAX) begin
            lim_in = COUNT_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= RESET_LIM;
      end else begin
         lim_ff <= lim_in;
      end
   end

   assign req_stall = q_full;
   assign accept = req_valid && !q_full;

   jsu_front #(
      .COUNT_BITS(COUNT_BITS),
      .CW(CW)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .lim(lim_ff),
      .accept(accept),
      .in_byte(req_in_byte),
      .in_last(req_in_last),
      .push(push),
      .entry(push_entry),
      .base(push_base)
   );

   jsu_queue #(
      .COUNT_BITS(COUNT_BITS)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_entry(push_entry),
      .push_base(push_base),
      .pop(pop),
      .full(q_full),
      .empty(q_empty),
      .head_entry(head_entry),
      .head_base(head_base)
   );

   jsu_back #(
      .COUNT_BITS(COUNT_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .empty(q_empty),
      .head_entry(head_entry),
      .head_base(head_base),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_byte_valid(rsp_byte_valid),
      .rsp_end_of_string(rsp_end_of_string),
      .rsp_out_length(rsp_out_length)
   );

endmodule

### rtl/jsu_checker.sv
// Port-level checks for the JSON string unescaper, bound to the top level.
module jsu_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic rsp_byte_valid,
   input logic rsp_end_of_string,
   input logic [19:0] rsp_out_length
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_out_length) && $stable(rsp_end_of_string))
      else $error("result word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_marker_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_end_of_string && rsp_out_byte == 8'd0)
      else $error("end marker without end of string");

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> rsp_out_length != 20'd0)
      else $error("data word with zero length");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_out_byte(rsp_out_byte),
   .rsp_byte_valid(rsp_byte_valid),
   .rsp_end_of_string(rsp_end_of_string),
   .rsp_out_length(rsp_out_length)
);
